// ----- design/nearest_point_search_3d_unit_macros.svh -----
// assertion macros used by the checker file
`ifndef NEAREST_POINT_SEARCH_3D_UNIT_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define NPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define NPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nps_pkg.sv -----
// package: constants, types and codes of the nearest point search unit
`default_nettype none

package nps_pkg;

    localparam int MAX_POINTS = 128;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int ITER_W  = $clog2(ROOT_W);

    localparam int POS_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam int IDX_W  = 7;
    localparam int DIST_W = 26;

    localparam int S_TDATA_W = 3 * COORD_W;
    localparam int M_FIELD_W = IDX_W + DIST_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Z = 2'd2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one classified point between front and back
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [POS_W-1:0]         pos;
        logic                     first;
        logic                     skip;
        logic                     last;
        logic                     ovf;
    } nps_entry_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_HOLD
    } nps_sqrt_state_t;

endpackage

`default_nettype wire

// ----- design/nps_front.sv -----
// front end: reference registers, point differences, set counter and classification
`default_nettype none

module nps_front
    import nps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  q_full,
    output logic                       q_push,
    output nps_entry_t                 q_entry
);

    logic [COORD_W-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               full;
    logic [COORD_W-1:0] pt_x, pt_y, pt_z;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign pt_x = s_axis_tdata[COORD_W-1:0];
    assign pt_y = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign pt_z = s_axis_tdata[3*COORD_W-1:2*COORD_W];

    assign full = (cnt_reg == CNT_W'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REF_X: ref_x_reg <= cfg_data;
                CFG_REF_Y: ref_y_reg <= cfg_data;
                CFG_REF_Z: ref_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // differences are reference minus candidate, exact in one extra bit
    always_comb begin
        q_entry.dx    = $signed({ref_x_reg[COORD_W-1], ref_x_reg}) -
                        $signed({pt_x[COORD_W-1], pt_x});
        q_entry.dy    = $signed({ref_y_reg[COORD_W-1], ref_y_reg}) -
                        $signed({pt_y[COORD_W-1], pt_y});
        q_entry.dz    = $signed({ref_z_reg[COORD_W-1], ref_z_reg}) -
                        $signed({pt_z[COORD_W-1], pt_z});
        q_entry.pos   = cnt_reg[POS_W-1:0];
        q_entry.first = (cnt_reg == '0);
        q_entry.skip  = full;
        q_entry.last  = s_axis_tlast;
        q_entry.ovf   = ovf_reg || full;
    end

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (q_push) begin
            if (s_axis_tlast) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end else if (full) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/nps_fifo.sv -----
// short queue of classified points between front and back
`default_nettype none

module nps_fifo
    import nps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire nps_entry_t  push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             valid,
    output nps_entry_t       head_entry
);

    nps_entry_t            slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign valid      = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/nps_back.sv -----
// back end: squares, running minimum, iterative square root and result register
`default_nettype none

module nps_back
    import nps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire nps_entry_t           q_entry,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] r;
        r = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return r;
    endfunction

    // square stage
    logic              s1_valid_reg;
    nps_entry_t        s1_reg;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIFF_W-1:0] mag_x, mag_y, mag_z;

    // compare stage
    logic [SQ_W-1:0]  best_reg;
    logic [POS_W-1:0] best_pos_reg;
    logic [SQ_W-1:0]  cand_sum;
    logic             take, s1_adv;

    // square root sequencer
    nps_sqrt_state_t  sq_state_reg, sq_state_next;
    logic [SQ_W-1:0]  op_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [POS_W-1:0] res_pos_reg;
    logic             res_ovf_reg;
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;
    logic             sq_start, sq_step, out_load;

    logic             out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    assign s1_adv = s1_valid_reg && (!s1_reg.last || sq_state_reg == SQ_IDLE);
    assign q_pop  = q_valid && (!s1_valid_reg || s1_adv);

    assign mag_x = mag(q_entry.dx);
    assign mag_y = mag(q_entry.dy);
    assign mag_z = mag(q_entry.dz);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_reg   <= q_entry;
            sq_x_reg <= SQ_W'(mag_x) * SQ_W'(mag_x);
            sq_y_reg <= SQ_W'(mag_y) * SQ_W'(mag_y);
            sq_z_reg <= SQ_W'(mag_z) * SQ_W'(mag_z);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (q_pop) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // sum of three squares stays below 2^50, ties keep the earlier point
    assign cand_sum = sq_x_reg + sq_y_reg + sq_z_reg;
    assign take     = !s1_reg.skip && (s1_reg.first || cand_sum < best_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg     <= '0;
            best_pos_reg <= '0;
        end else if (s1_adv && take) begin
            best_reg     <= cand_sum;
            best_pos_reg <= s1_reg.pos;
        end
    end

    // one root bit per cycle, restoring method
    assign rem_sh = {rem_reg[ROOT_W-1:0], op_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        sq_state_next = sq_state_reg;
        sq_start      = 1'b0;
        sq_step       = 1'b0;
        out_load      = 1'b0;
        unique case (sq_state_reg)
            SQ_IDLE: begin
                if (s1_adv && s1_reg.last) begin
                    sq_start      = 1'b1;
                    sq_state_next = SQ_RUN;
                end
            end
            SQ_RUN: begin
                sq_step = 1'b1;
                if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                    sq_state_next = SQ_HOLD;
                end
            end
            SQ_HOLD: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_load      = 1'b1;
                    sq_state_next = SQ_IDLE;
                end
            end
            default: sq_state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_state_reg <= SQ_IDLE;
        end else begin
            sq_state_reg <= sq_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_start) begin
            op_reg      <= take ? cand_sum : best_reg;
            res_pos_reg <= take ? s1_reg.pos : best_pos_reg;
            res_ovf_reg <= s1_reg.ovf;
            rem_reg     <= '0;
            root_reg    <= '0;
            iter_reg    <= '0;
        end else if (sq_step) begin
            op_reg   <= op_reg << 2;
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            iter_reg <= iter_reg + ITER_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= M_TDATA_W'({res_ovf_reg, DIST_W'(root_reg), IDX_W'(res_pos_reg)});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- design/nearest_point_search_3d_unit.sv -----
// top level: linear nearest point search in three dimensions
//
// input stream s_axis: one word per candidate point, x/y/z in signed Q16.8,
// s_axis_tlast marks the final point of a set
// result stream m_axis: one word per set, sent after the tlast point
// config channel cfg_*: reference point x/y/z at indexes 0/1/2, always ready,
// write only while no set is in flight
// throughput: one point per cycle within a set while the queue is not full; the front
// queue decouples input from back; from tlast to m_axis_tvalid the last point passes
// the queue, square stage, root start, the one-bit-per-cycle square root and the
// output register
// a tlast word waits while the previous set's root is still running or its finished
// root still waits for the result before it to leave the output register
// points beyond MAX_POINTS in a set are not compared and raise overflow
// reset (aresetn low, synchronous) clears reference point, set state,
// queue and output; a stalled result holds until m_axis_tready
`default_nettype none

module nearest_point_search_3d_unit
    import nps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // candidate points
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // point_x, point_y, point_z
    input  wire logic                  s_axis_tlast,  // last_point
    // results
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata   // closest_index, closest_distance,
                                                      // overflow, zero pad
);

    logic       q_push, q_full, q_pop, q_valid;
    nps_entry_t q_in, q_head;

    // front: registers, differences, set position and overflow marking
    nps_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    // two-word queue so the back can stall during a root without losing points
    nps_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (q_head)
    );

    // back: squares, minimum, root and output register
    nps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- design/nps_checker.sv -----
// port-level checker for the nearest point search unit, with its bind
`default_nettype none

`include "nearest_point_search_3d_unit_macros.svh"

module nps_checker
    import nps_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 cfg_ready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    // stalled result word holds
    `NPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // root of a sum below 2^50 never sets the top distance bit, pad is zero
    `NPS_ASSERT_SAME(a_pad, aclk, aresetn, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:IDX_W+DIST_W-1] == '0 || m_axis_tdata[M_TDATA_W-1:IDX_W+DIST_W-1] == {{(M_TDATA_W-IDX_W-DIST_W-1){1'b0}}, 1'b1, 1'b0}, "distance top bit or pad bits set")

    // reset empties the output register
    `NPS_ASSERT_NEXT(a_rst, aclk, 1'b1, !aresetn, !m_axis_tvalid, "result valid right after reset")

    // configuration never back-pressures
    `NPS_ASSERT_SAME(a_cfg, aclk, aresetn, 1'b1, cfg_ready, "config channel not ready")

endmodule

bind nearest_point_search_3d_unit nps_checker u_nps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_ready     (cfg_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
